### rtl/core/gcrqc_pkg.sv
package gcrqc_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int COUNT_WIDTH_DEF = 24;

  localparam int OUT_W  = 24;
  localparam int IDX_W  = 12;
  localparam int RATE_W = 17;
  // widths sized for the largest sample count the block supports
  localparam int AC_W   = 18;
  localparam int PC_W   = 17;

  localparam logic [RATE_W-1:0] RATE_RESET = 17'd62259;

  localparam logic OP_GENO  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] GT_MISSING = 2'd0;
  localparam logic [1:0] GT_AA      = 2'd1;
  localparam logic [1:0] GT_AB      = 2'd2;
  localparam logic [1:0] GT_BB      = 2'd3;

  localparam logic [1:0] CLS_AUT   = 2'd0;
  localparam logic [1:0] CLS_X     = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  localparam logic KIND_SNP    = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic             op;
    logic [1:0]       genotype;
    logic [1:0]       chrom_class;
    logic             last_sample;
    logic [IDX_W-1:0] sample_index;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [RATE_W-1:0] snp_call_rate_q16;
    logic [RATE_W-1:0] major_freq_q16;
    logic              major_is_b;
    logic              no_calls;
    logic              passed;
    logic [OUT_W-1:0]  sample_called;
    logic [OUT_W-1:0]  aut_called;
    logic [OUT_W-1:0]  aut_hets;
    logic [OUT_W-1:0]  x_called;
    logic [OUT_W-1:0]  x_hets;
    logic [OUT_W-1:0]  good_snp_count;
  } out_item_t;

  typedef struct packed {
    logic             is_query;
    logic [1:0]       cls;
    logic [IDX_W-1:0] idx;
    logic [AC_W-1:0]  a_cnt;
    logic [AC_W-1:0]  b_cnt;
    logic [PC_W-1:0]  miss;
    logic [PC_W-1:0]  n;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic snp_done;
  } bk_stat_t;

endpackage

### rtl/core/gcrqc_ram.sv
module gcrqc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/gcrqc_front.sv
module gcrqc_front #(
  parameter int MAX_SAMPLES = gcrqc_pkg::MAX_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  gcrqc_pkg::in_item_t        in_data,
  input  gcrqc_pkg::bk_stat_t        bk_stat,
  input  logic                       q_full,
  output logic                       q_push,
  output gcrqc_pkg::cmd_t            q_cmd,
  output logic                       gb_wr_en,
  output logic [$clog2(MAX_SAMPLES)-1:0] gb_wr_addr,
  output logic [1:0]                 gb_wr_data
);

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int PW  = $clog2(MAX_SAMPLES + 1);
  localparam int CW2 = $clog2(2 * MAX_SAMPLES + 1);
  localparam int ACW = gcrqc_pkg::AC_W;
  localparam int PCW = gcrqc_pkg::PC_W;

  logic [PW-1:0]  pos_r, pos_nxt, miss_r, miss_nxt;
  logic [CW2-1:0] a_r, a_nxt, b_r, b_nxt;
  logic           snp_busy_r;
  logic           acc, geno, room;

  assign in_stall = !bk_stat.ready || q_full ||
                    (in_data.op == gcrqc_pkg::OP_GENO && snp_busy_r);
  assign acc  = in_valid && !in_stall;
  assign geno = acc && in_data.op == gcrqc_pkg::OP_GENO;
  assign room = pos_r < PW'(MAX_SAMPLES);

  assign gb_wr_en   = geno && room;
  assign gb_wr_addr = pos_r[AW-1:0];
  assign gb_wr_data = in_data.genotype;

  always_comb begin
    pos_nxt  = pos_r;
    miss_nxt = miss_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (gb_wr_en) begin
      pos_nxt = pos_r + PW'(1);
      case (in_data.genotype)
        gcrqc_pkg::GT_MISSING: miss_nxt = miss_r + PW'(1);
        gcrqc_pkg::GT_AA:      a_nxt = a_r + CW2'(2);
        gcrqc_pkg::GT_AB: begin
          a_nxt = a_r + CW2'(1);
          b_nxt = b_r + CW2'(1);
        end
        default:               b_nxt = b_r + CW2'(2);
      endcase
    end
  end

  assign q_push = acc && (in_data.op == gcrqc_pkg::OP_QUERY || in_data.last_sample);

  always_comb begin
    q_cmd.is_query = in_data.op == gcrqc_pkg::OP_QUERY;
    q_cmd.cls      = in_data.chrom_class;
    q_cmd.idx      = in_data.sample_index;
    q_cmd.a_cnt    = ACW'(a_nxt);
    q_cmd.b_cnt    = ACW'(b_nxt);
    q_cmd.miss     = PCW'(miss_nxt);
    q_cmd.n        = PCW'(pos_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      miss_r     <= '0;
      a_r        <= '0;
      b_r        <= '0;
      snp_busy_r <= 1'b0;
    end else begin
      if (geno && in_data.last_sample) begin
        pos_r      <= '0;
        miss_r     <= '0;
        a_r        <= '0;
        b_r        <= '0;
        snp_busy_r <= 1'b1;
      end else begin
        pos_r  <= pos_nxt;
        miss_r <= miss_nxt;
        a_r    <= a_nxt;
        b_r    <= b_nxt;
        if (bk_stat.snp_done) begin
          snp_busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/core/gcrqc_queue.sv
module gcrqc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gcrqc_pkg::cmd_t push_cmd,
  input  logic            pop,
  output gcrqc_pkg::cmd_t head,
  output logic            empty,
  output logic            full
);

  gcrqc_pkg::cmd_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = cnt_r == 2'd0;
  assign full  = cnt_r == 2'd2;
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/core/gcrqc_div.sv
module gcrqc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [gcrqc_pkg::AC_W-1:0]     num,
  input  logic [gcrqc_pkg::AC_W-1:0]     den,
  output logic                           done,
  output logic [gcrqc_pkg::RATE_W-1:0]   quot
);

  // floor(num * 2^16 / den) for num <= den, one quotient bit a cycle
  localparam int DW = gcrqc_pkg::AC_W;
  localparam int QW = gcrqc_pkg::RATE_W;

  logic [DW:0]   rem_r, trial, diff;
  logic [DW-1:0] den_r;
  logic [QW-1:0] q_r;
  logic [4:0]    cnt_r;
  logic          busy_r, done_r, ge;

  assign trial = (cnt_r == 5'd0) ? rem_r : {rem_r[DW-1:0], 1'b0};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign done  = done_r;
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && cnt_r == 5'(QW - 1);
      if (start) begin
        rem_r  <= {1'b0, num};
        den_r  <= den;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff : trial;
        q_r   <= {q_r[QW-2:0], ge};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(QW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/core/gcrqc_back.sv
module gcrqc_back #(
  parameter int MAX_SAMPLES = gcrqc_pkg::MAX_SAMPLES_DEF,
  parameter int COUNT_WIDTH = gcrqc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [gcrqc_pkg::RATE_W-1:0]   min_rate,
  input  gcrqc_pkg::cmd_t                q_head,
  input  logic                           q_empty,
  output logic                           q_pop,
  output gcrqc_pkg::bk_stat_t            bk_stat,
  output logic [$clog2(MAX_SAMPLES)-1:0] gb_rd_addr,
  input  logic [1:0]                     gb_rd_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gcrqc_pkg::out_item_t           out_data
);

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = COUNT_WIDTH;
  localparam int OW  = gcrqc_pkg::OUT_W;
  localparam int ACW = gcrqc_pkg::AC_W;
  localparam int PCW = gcrqc_pkg::PC_W;
  localparam int RW  = gcrqc_pkg::RATE_W;
  localparam logic [CW-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RATE_GO, S_RATE_WAIT, S_FREQ_GO, S_FREQ_WAIT,
    S_DECIDE, S_REPLAY, S_DRAIN, S_QREAD, S_QRES
  } state_t;

  state_t               state_r;
  gcrqc_pkg::cmd_t      cmd_r;
  logic [AW-1:0]        clr_addr_r, i_r, rp_addr_r;
  logic                 rp_v_r, snp_done_r, out_valid_r;
  gcrqc_pkg::out_item_t out_r, out_nxt;
  logic [RW-1:0]        rate_r, freq_r;
  logic [CW-1:0]        passing_r, passing_inc;

  logic [ACW-1:0] called_w, slots_w, major_w;
  logic           is_b_w, pass_w, out_free, in_range, last_issue, load_out;
  logic           div_start, div_done;
  logic [ACW-1:0] div_num, div_den;
  logic [RW-1:0]  div_q;

  logic            cr_wr_en;
  logic [AW-1:0]   cr_wr_addr, cr_rd_addr;
  logic [5*CW-1:0] cr_wr_data, cr_rd_data;
  logic [CW-1:0]   c_called, c_aut, c_auth, c_x, c_xh;
  logic [CW-1:0]   n_called, n_aut, n_auth, n_x, n_xh;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c,
                                                  input logic en);
    bump = (en && c != CNT_MAX) ? c + COUNT_WIDTH'(1) : c;
  endfunction

  assign called_w = cmd_r.a_cnt + cmd_r.b_cnt;
  assign slots_w  = called_w + {cmd_r.miss, 1'b0};
  assign is_b_w   = cmd_r.b_cnt > cmd_r.a_cnt;
  assign major_w  = is_b_w ? cmd_r.b_cnt : cmd_r.a_cnt;
  assign pass_w   = called_w != '0 && rate_r >= min_rate;
  assign passing_inc = bump(passing_r, 1'b1);
  assign out_free = !out_valid_r || !out_stall;
  assign in_range = 32'(cmd_r.idx) < 32'(MAX_SAMPLES);
  assign last_issue = PCW'(i_r) + PCW'(1) == cmd_r.n;
  assign load_out = out_free && (state_r == S_DECIDE || state_r == S_QRES);

  assign div_start = state_r == S_RATE_GO || state_r == S_FREQ_GO;
  assign div_num   = (state_r == S_RATE_GO) ? called_w : major_w;
  assign div_den   = (state_r == S_RATE_GO) ? slots_w : called_w;

  gcrqc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign q_pop            = state_r == S_IDLE && !q_empty;
  assign bk_stat.ready    = state_r != S_CLEAR;
  assign bk_stat.snp_done = snp_done_r;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

  assign gb_rd_addr = i_r;
  assign cr_rd_addr = (state_r == S_QREAD || state_r == S_QRES) ? AW'(cmd_r.idx) : i_r;

  assign c_called = cr_rd_data[5*CW-1:4*CW];
  assign c_aut    = cr_rd_data[4*CW-1:3*CW];
  assign c_auth   = cr_rd_data[3*CW-1:2*CW];
  assign c_x      = cr_rd_data[2*CW-1:CW];
  assign c_xh     = cr_rd_data[CW-1:0];

  // replay update of one sample from the counters read last cycle
  always_comb begin
    logic called, het, x_cls, aut_cls;
    called  = gb_rd_data != gcrqc_pkg::GT_MISSING;
    het     = gb_rd_data == gcrqc_pkg::GT_AB;
    x_cls   = cmd_r.cls == gcrqc_pkg::CLS_X;
    aut_cls = !x_cls && cmd_r.cls != gcrqc_pkg::CLS_OTHER;
    n_called = bump(c_called, called);
    n_x      = bump(c_x, called && x_cls);
    n_xh     = bump(c_xh, het && x_cls);
    n_aut    = bump(c_aut, called && aut_cls);
    n_auth   = bump(c_auth, het && aut_cls);
  end

  always_comb begin
    out_nxt = '0;
    if (state_r == S_QRES) begin
      out_nxt.kind           = gcrqc_pkg::KIND_SAMPLE;
      out_nxt.good_snp_count = OW'(passing_r);
      if (in_range) begin
        out_nxt.sample_called = OW'(c_called);
        out_nxt.aut_called    = OW'(c_aut);
        out_nxt.aut_hets      = OW'(c_auth);
        out_nxt.x_called      = OW'(c_x);
        out_nxt.x_hets        = OW'(c_xh);
      end
    end else begin
      out_nxt.kind              = gcrqc_pkg::KIND_SNP;
      out_nxt.snp_call_rate_q16 = rate_r;
      out_nxt.major_freq_q16    = freq_r;
      out_nxt.major_is_b        = called_w != '0 && is_b_w;
      out_nxt.no_calls          = called_w == '0;
      out_nxt.passed            = pass_w;
      out_nxt.good_snp_count    = OW'(pass_w ? passing_inc : passing_r);
    end
  end

  assign cr_wr_en   = state_r == S_CLEAR || rp_v_r;
  assign cr_wr_addr = (state_r == S_CLEAR) ? clr_addr_r : rp_addr_r;
  assign cr_wr_data = (state_r == S_CLEAR) ? '0 : {n_called, n_aut, n_auth, n_x, n_xh};

  gcrqc_ram #(
    .WIDTH (5 * CW),
    .DEPTH (MAX_SAMPLES)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cr_wr_en),
    .wr_addr (cr_wr_addr),
    .wr_data (cr_wr_data),
    .rd_addr (cr_rd_addr),
    .rd_data (cr_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      i_r         <= '0;
      rp_v_r      <= 1'b0;
      snp_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
      passing_r   <= '0;
    end else begin
      snp_done_r <= (state_r == S_DECIDE && out_free && !pass_w) || state_r == S_DRAIN;
      rp_v_r     <= state_r == S_REPLAY;
      rp_addr_r  <= i_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_r       <= out_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(MAX_SAMPLES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          i_r <= '0;
          if (!q_empty) begin
            cmd_r   <= q_head;
            state_r <= q_head.is_query ? S_QREAD : S_RATE_GO;
          end
        end
        S_RATE_GO: begin
          rate_r  <= '0;
          freq_r  <= '0;
          state_r <= (slots_w == '0) ? S_FREQ_GO : S_RATE_WAIT;
        end
        S_RATE_WAIT: begin
          if (div_done) begin
            rate_r  <= div_q;
            state_r <= S_FREQ_GO;
          end
        end
        S_FREQ_GO: begin
          state_r <= (called_w == '0) ? S_DECIDE : S_FREQ_WAIT;
        end
        S_FREQ_WAIT: begin
          if (div_done) begin
            freq_r  <= div_q;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            if (pass_w) begin
              passing_r <= passing_inc;
              state_r   <= S_REPLAY;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_REPLAY: begin
          i_r <= i_r + AW'(1);
          if (last_issue) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_IDLE;
        end
        S_QREAD: begin
          state_r <= S_QRES;
        end
        S_QRES: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/genotype_call_rate_allele_freq_qc_unit.sv
// Channel  Direction  Payload                  Handshake
// in_      input      gcrqc_pkg::in_item_t     in_valid / in_stall
// out_     output     gcrqc_pkg::out_item_t    out_valid / out_stall
// cfg_     input      min call rate, 17 bit    cfg_wr_en
//
// A genotype item is taken in any cycle with in_stall low. A closed SNP gives its result
// after two 17-bit divisions for call rate and major allele frequency, each skipped for a
// zero divisor; a passing SNP then replays one sample per cycle into the counter memory.
// An idle query is answered from the counter memory. After reset all MAX_SAMPLES counter
// entries are cleared with in_stall high. Genotypes stall until a closed SNP is done, after
// a failing result or the replay of a passing one; queries go on queueing behind it.
module genotype_call_rate_allele_freq_qc_unit #(
  parameter int MAX_SAMPLES = gcrqc_pkg::MAX_SAMPLES_DEF,
  parameter int COUNT_WIDTH = gcrqc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  gcrqc_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output gcrqc_pkg::out_item_t         out_data,
  input  logic                         cfg_wr_en,
  input  logic [gcrqc_pkg::RATE_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(MAX_SAMPLES);

  logic [gcrqc_pkg::RATE_W-1:0] min_rate_r;
  gcrqc_pkg::bk_stat_t bk_stat;
  gcrqc_pkg::cmd_t     q_cmd, q_head;
  logic                q_push, q_pop, q_empty, q_full;
  logic                gb_wr_en;
  logic [AW-1:0]       gb_wr_addr, gb_rd_addr;
  logic [1:0]          gb_wr_data, gb_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r <= gcrqc_pkg::RATE_RESET;
    end else if (cfg_wr_en) begin
      min_rate_r <= cfg_wr_data;
    end
  end

  gcrqc_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .bk_stat    (bk_stat),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .gb_wr_en   (gb_wr_en),
    .gb_wr_addr (gb_wr_addr),
    .gb_wr_data (gb_wr_data)
  );

  gcrqc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_SAMPLES)
  ) u_geno_ram (
    .clk     (clk),
    .wr_en   (gb_wr_en),
    .wr_addr (gb_wr_addr),
    .wr_data (gb_wr_data),
    .rd_addr (gb_rd_addr),
    .rd_data (gb_rd_data)
  );

  gcrqc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  gcrqc_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .min_rate   (min_rate_r),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .bk_stat    (bk_stat),
    .gb_rd_addr (gb_rd_addr),
    .gb_rd_data (gb_rd_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### rtl/core/gcrqc_checker.sv
module gcrqc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input gcrqc_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_nocall_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == gcrqc_pkg::KIND_SNP && out_data.no_calls |->
      !out_data.passed && out_data.major_freq_q16 == '0 && !out_data.major_is_b)
    else $error("SNP without calls reported as passing or with a frequency");

  a_major_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == gcrqc_pkg::KIND_SNP && !out_data.no_calls |->
      out_data.major_freq_q16 >= 17'd32768)
    else $error("major allele frequency below one half");

  a_query_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == gcrqc_pkg::KIND_SAMPLE |->
      out_data.snp_call_rate_q16 == '0 && !out_data.passed && !out_data.no_calls)
    else $error("sample result carries SNP fields");

endmodule

bind genotype_call_rate_allele_freq_qc_unit gcrqc_checker u_chk (.*);
